// File: hw/rtl/assert_macros.svh
// assertion macros used by gql_ctrl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// condition that must hold on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

`endif

// File: hw/rtl/gql_pkg.sv
// shared types and constants for the glyph quad layout block
// no dependencies
`default_nettype none
package gql_pkg;

   localparam int CfgBits = 13;
   localparam int CfgIdxBits = 1;
   localparam logic [CfgIdxBits-1:0] CSR_IMAGE_WIDTH = 1'b0;
   localparam logic [CfgIdxBits-1:0] CSR_IMAGE_HEIGHT = 1'b1;
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_CHAR = 1'b1;
   localparam int PosXBits = 22;
   localparam int PosYBits = 12;
   localparam int TexBits = 17;

   // controller to datapath commands
   typedef struct packed {
      logic capture;    // latch the accepted transaction
      logic div_start;  // start one coordinate division
      logic [1:0] div_sel;  // 0 u0, 1 u1, 2 v0, 3 v1
      logic div_store;  // store quotient of finished division
      logic emit;       // load the output register with a corner
      logic [1:0] corner;
      logic pen_update;
   } ctl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic div_done;
   } ctl_sts_type;

endpackage
`default_nettype wire

// File: hw/rtl/gql_ctrl.sv
// controller state machine for the glyph quad layout block
// uses gql_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module gql_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  wire logic req_operation,
   output logic req_stall,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output gql_pkg::ctl_cmd_type cmd,
   input  gql_pkg::ctl_sts_type sts
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_START = 5'b00010,
      ST_DIV = 5'b00100,
      ST_EMIT = 5'b01000,
      ST_HOLD = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] sel_ff, sel_in;
   logic [1:0] corner_ff, corner_in;
   logic valid_ff, valid_in;

   // next state
   always_comb begin
      state_in = state_ff;
      sel_in = sel_ff;
      corner_in = corner_ff;
      valid_in = valid_ff;
      cmd = '0;
      cmd.div_sel = sel_ff;
      cmd.corner = corner_ff;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_operation == gql_pkg::OP_CHAR) begin
                  state_in = ST_START;
                  sel_in = 2'd0;
               end
            end
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_done) begin
               cmd.div_store = 1'b1;
               sel_in = sel_ff + 2'd1;
               if (sel_ff == 2'd3) begin
                  state_in = ST_EMIT;
                  corner_in = 2'd0;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         ST_EMIT: begin
            if (!valid_ff || !rsp_stall) begin
               cmd.emit = 1'b1;
               valid_in = 1'b1;
               corner_in = corner_ff + 2'd1;
               if (corner_ff == 2'd3) begin
                  cmd.pen_update = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_HOLD: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff <= 2'd0;
         corner_ff <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff <= sel_in;
         corner_ff <= corner_in;
         valid_ff <= valid_in;
      end
   end

   `ASSERT_ALWAYS(a_onehot_state, clock, reset, $onehot(state_ff))
   `ASSERT_IMPL(a_emit_only_in_emit, clock, reset, cmd.emit, state_ff == ST_EMIT)
   `ASSERT_IMPL(a_store_after_done, clock, reset, cmd.div_store, sts.div_done)

endmodule
`default_nettype wire

// File: hw/rtl/gql_datapath.sv
// datapath: descriptor table, serial divider, pen and output register
// uses gql_pkg
`default_nettype none
module gql_datapath #(
   parameter int GLYPH_COUNT = 256,
   parameter int CURSOR_BITS = 20,
   parameter int UV_FRACTION_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  gql_pkg::ctl_cmd_type cmd,
   output gql_pkg::ctl_sts_type sts,
   input  wire logic csr_write,
   input  wire logic [gql_pkg::CfgIdxBits-1:0] csr_index,
   input  wire logic [gql_pkg::CfgBits-1:0] csr_data,
   input  wire logic req_operation,
   input  wire logic [7:0] req_glyph_code,
   input  wire logic req_first_char,
   input  wire logic [11:0] req_atlas_x,
   input  wire logic [11:0] req_atlas_y,
   input  wire logic [9:0] req_glyph_width,
   input  wire logic [9:0] req_glyph_height,
   input  wire logic signed [10:0] req_origin_x,
   input  wire logic signed [10:0] req_origin_y,
   input  wire logic [9:0] req_advance,
   output logic [1:0] rsp_corner,
   output logic signed [gql_pkg::PosXBits-1:0] rsp_pos_x,
   output logic signed [gql_pkg::PosYBits-1:0] rsp_pos_y,
   output logic [gql_pkg::TexBits-1:0] rsp_tex_u,
   output logic [gql_pkg::TexBits-1:0] rsp_tex_v,
   output logic rsp_last_corner
);

   localparam int IdxBits = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
   localparam int EntBits = 76;
   localparam int NumBits = 13 + UV_FRACTION_BITS;
   localparam int CntBits = $clog2(NumBits + 1);
   localparam logic [CntBits-1:0] NumLast = CntBits'(NumBits - 1);
   localparam logic [NumBits-1:0] UvOne = NumBits'(1) << UV_FRACTION_BITS;
   localparam logic [CURSOR_BITS:0] PenMax = {1'b0, {CURSOR_BITS{1'b1}}};
   localparam int PxW = (CURSOR_BITS + 3 > 23) ? CURSOR_BITS + 3 : 23;
   localparam logic signed [PxW-1:0] PxMax = PxW'(64'sd2097151);
   localparam logic signed [PxW-1:0] PxMin = PxW'(-64'sd2097152);

   // descriptor memory with valid bits for reset clearing
   logic [EntBits-1:0] mem [GLYPH_COUNT];
   logic [GLYPH_COUNT-1:0] vld_ff;
   logic [EntBits-1:0] rd_ff;
   logic rdv_ff;
   logic in_range;
   assign in_range = ({1'b0, req_glyph_code} < 9'(GLYPH_COUNT));

   always_ff @(posedge clock) begin
      if (cmd.capture && in_range) begin
         if (req_operation == gql_pkg::OP_LOAD) begin
            mem[req_glyph_code[IdxBits-1:0]] <= {req_atlas_x, req_atlas_y,
               req_glyph_width, req_glyph_height, req_origin_x, req_origin_y,
               req_advance};
         end
         rd_ff <= mem[req_glyph_code[IdxBits-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rdv_ff <= 1'b0;
      end else if (cmd.capture) begin
         rdv_ff <= in_range && vld_ff[req_glyph_code[IdxBits-1:0]];
         if (in_range && req_operation == gql_pkg::OP_LOAD) begin
            vld_ff[req_glyph_code[IdxBits-1:0]] <= 1'b1;
         end
      end
   end

   logic [EntBits-1:0] ent;
   assign ent = rdv_ff ? rd_ff : '0;
   logic [11:0] ax, ay;
   logic [9:0] gw, gh, adv;
   logic signed [10:0] ox, oy;
   assign {ax, ay, gw, gh, ox, oy, adv} = ent;

   // configuration registers
   logic [12:0] imw_ff, imh_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         imw_ff <= 13'd256;
         imh_ff <= 13'd256;
      end else if (csr_write) begin
         unique case (csr_index)
            gql_pkg::CSR_IMAGE_WIDTH: imw_ff <= csr_data;
            gql_pkg::CSR_IMAGE_HEIGHT: imh_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // pen cursor
   logic [CURSOR_BITS-1:0] pen_ff;
   logic [CURSOR_BITS:0] pen_sum;
   assign pen_sum = {1'b0, pen_ff} + (CURSOR_BITS+1)'(adv);
   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff <= '0;
      end else if (cmd.capture && req_operation == gql_pkg::OP_CHAR && req_first_char) begin
         pen_ff <= '0;
      end else if (cmd.pen_update) begin
         pen_ff <= (pen_sum > PenMax) ? PenMax[CURSOR_BITS-1:0] : pen_sum[CURSOR_BITS-1:0];
      end
   end

   // restoring divider, one quotient bit a cycle
   logic [12:0] dnum;
   logic [12:0] dden;
   always_comb begin
      case (cmd.div_sel)
         2'd0: dnum = {1'b0, ax};
         2'd1: dnum = 13'({1'b0, ax} + 13'(gw));
         2'd2: dnum = {1'b0, ay};
         default: dnum = 13'({1'b0, ay} + 13'(gh));
      endcase
      dden = cmd.div_sel[1] ? imh_ff : imw_ff;
   end

   logic [NumBits-1:0] dvd_ff, quo_ff;
   logic [12:0] rem_ff;
   logic [12:0] den_ff;
   logic [CntBits-1:0] cnt_ff;
   logic busy_ff, done_ff;
   logic [13:0] trial;
   assign trial = {rem_ff, dvd_ff[NumBits-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.div_start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == NumLast) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dvd_ff <= {dnum, {UV_FRACTION_BITS{1'b0}}};
         rem_ff <= '0;
         quo_ff <= '0;
         den_ff <= dden;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= dvd_ff << 1;
         cnt_ff <= cnt_ff + CntBits'(1);
         if (trial >= {1'b0, den_ff}) begin
            rem_ff <= 13'(trial - {1'b0, den_ff});
            quo_ff <= {quo_ff[NumBits-2:0], 1'b1};
         end else begin
            rem_ff <= trial[12:0];
            quo_ff <= {quo_ff[NumBits-2:0], 1'b0};
         end
      end
   end
   assign sts.div_done = done_ff;

   // saturated coordinates
   logic [NumBits-1:0] sat_q;
   assign sat_q = (den_ff == '0 || quo_ff > UvOne) ? UvOne : quo_ff;
   logic [gql_pkg::TexBits-1:0] u0_ff, u1_ff, v0_ff, v1_ff;
   always_ff @(posedge clock) begin
      if (cmd.div_store) begin
         case (cmd.div_sel)
            2'd0: u0_ff <= gql_pkg::TexBits'(sat_q);
            2'd1: u1_ff <= gql_pkg::TexBits'(sat_q);
            2'd2: v0_ff <= gql_pkg::TexBits'(sat_q);
            default: v1_ff <= gql_pkg::TexBits'(sat_q);
         endcase
      end
   end

   // corner positions
   logic signed [PxW-1:0] left, right, lsat, rsat;
   logic signed [gql_pkg::PosYBits-1:0] bot, top;
   assign left = $signed(PxW'({1'b0, pen_ff})) - PxW'(ox);
   assign right = left + $signed(PxW'(gw));
   assign lsat = (left > PxMax) ? PxMax : ((left < PxMin) ? PxMin : left);
   assign rsat = (right > PxMax) ? PxMax : ((right < PxMin) ? PxMin : right);
   assign top = gql_pkg::PosYBits'(oy);
   assign bot = top - $signed(gql_pkg::PosYBits'(gh));

   // output register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_corner <= cmd.corner;
         rsp_last_corner <= (cmd.corner == 2'd3);
         rsp_pos_x <= gql_pkg::PosXBits'((cmd.corner == 2'd1 || cmd.corner == 2'd2)
            ? rsat : lsat);
         rsp_pos_y <= cmd.corner[1] ? top : bot;
         rsp_tex_u <= (cmd.corner == 2'd1 || cmd.corner == 2'd2) ? u1_ff : u0_ff;
         rsp_tex_v <= cmd.corner[1] ? v0_ff : v1_ff;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/glyph_quad_layout.sv
// glyph quad layout block: a load transaction writes a glyph descriptor, a
// character transaction yields four quad corner transactions.
// Channels: req_ (valid/stall) carries the item, rsp_ (valid/stall) the
// corners; csr_ writes image_width (index 0) and image_height (index 1).
// A load gives no result. A character runs the serial divider (one
// quotient bit a cycle) for each of the four coordinates, then gives
// the four corners from the output register.
// req_stall is high while a character is at work. When the receiver
// stalls the output register holds and the controller waits.
// Reset (synchronous, active high) clears the descriptor table through
// valid bits, the pen cursor, and sets both image sizes to 256.
// uses gql_pkg, gql_ctrl, gql_datapath
`default_nettype none
module glyph_quad_layout #(
   parameter int GLYPH_COUNT = 256,
   parameter int CURSOR_BITS = 20,
   parameter int UV_FRACTION_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_write,
   input  wire logic [gql_pkg::CfgIdxBits-1:0] csr_index,
   input  wire logic [gql_pkg::CfgBits-1:0] csr_data,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire logic req_operation,
   input  wire logic [7:0] req_glyph_code,
   input  wire logic req_first_char,
   input  wire logic [11:0] req_atlas_x,
   input  wire logic [11:0] req_atlas_y,
   input  wire logic [9:0] req_glyph_width,
   input  wire logic [9:0] req_glyph_height,
   input  wire logic signed [10:0] req_origin_x,
   input  wire logic signed [10:0] req_origin_y,
   input  wire logic [9:0] req_advance,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output logic [1:0] rsp_corner,
   output logic signed [gql_pkg::PosXBits-1:0] rsp_pos_x,
   output logic signed [gql_pkg::PosYBits-1:0] rsp_pos_y,
   output logic [gql_pkg::TexBits-1:0] rsp_tex_u,
   output logic [gql_pkg::TexBits-1:0] rsp_tex_v,
   output logic rsp_last_corner
);

   gql_pkg::ctl_cmd_type cmd;
   gql_pkg::ctl_sts_type sts;

   // controller
   gql_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_operation, .req_stall,
      .rsp_valid, .rsp_stall, .cmd, .sts
   );

   // datapath
   gql_datapath #(
      .GLYPH_COUNT(GLYPH_COUNT), .CURSOR_BITS(CURSOR_BITS),
      .UV_FRACTION_BITS(UV_FRACTION_BITS)
   ) u_dp (
      .clock, .reset, .cmd, .sts, .csr_write, .csr_index, .csr_data,
      .req_operation, .req_glyph_code, .req_first_char, .req_atlas_x,
      .req_atlas_y, .req_glyph_width, .req_glyph_height, .req_origin_x,
      .req_origin_y, .req_advance, .rsp_corner, .rsp_pos_x, .rsp_pos_y,
      .rsp_tex_u, .rsp_tex_v, .rsp_last_corner
   );

endmodule
`default_nettype wire
